/* hdl/mma_pkg.sv */
package mma_pkg;

    localparam int CHANNELS_DEF   = 12;
    localparam int MAX_WINDOW_DEF = 128;

    localparam int CH_W     = 4;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 24;
    localparam int WIN_W    = 7;

    localparam int WIN_LOW   = 2;
    localparam int WIN_HIGH  = 100;
    localparam int WIN_RESET = 2;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       new_series;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]            out_channel;
        logic signed [SAMPLE_W-1:0] average;
        logic                       warming_up;
    } t_out_item;

endpackage

/* hdl/multichannel_moving_average.sv */
// channel  | direction | handshake          | payload
// in       | input     | i_in_valid/o_in_stall   | t_in_item
// out      | output    | o_out_valid/i_out_stall | t_out_item
// cfg      | input     | i_cfg_valid/o_cfg_ready | window_len, 7 bits
//
// one item at a time: the result reaches the output register through S_OUT,
// straight from S_IDLE for an out-of-range channel, after S_RD1 and S_RD2 for warm-up,
// and also after S_DIV for an averaged result, set by the 24-step restoring divider
// (one quotient bit per cycle); the next item is taken once the block is back in S_IDLE
// synchronous active-low reset clears every channel's valid bit, so its sum, count and
// slot read back as cleared; the state and sample history memories need no clearing
// the output register lets the next item in while a result waits on stall
module multichannel_moving_average #(
    parameter int CHANNELS   = mma_pkg::CHANNELS_DEF,
    parameter int MAX_WINDOW = mma_pkg::MAX_WINDOW_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  mma_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output mma_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [mma_pkg::WIN_W-1:0] i_cfg_data
);

    import mma_pkg::*;

    localparam int CI_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W   = $clog2(MAX_WINDOW);
    localparam int HIST_D   = CHANNELS * MAX_WINDOW;
    localparam int HA_W     = (HIST_D > 1) ? $clog2(HIST_D) : 1;
    localparam int ST_W     = SUM_W + WIN_W + SLOT_W;
    localparam int EFF_HIGH = (WIN_HIGH < MAX_WINDOW) ? WIN_HIGH : MAX_WINDOW;
    localparam int PW       = ((SLOT_W > WIN_W) ? SLOT_W : WIN_W) + 1;
    localparam logic [CH_W+2:0] CH_LIM = (CH_W + 3)'(CHANNELS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_DIV,
        S_OUT
    } t_state;

    t_state            r_state;
    t_in_item          r_item;
    logic [CI_W-1:0]   r_ch;
    logic [HA_W-1:0]   r_base;
    logic [SUM_W-1:0]  r_sum;
    logic [WIN_W-1:0]  r_cnt;
    logic [SLOT_W-1:0] r_slot;
    logic              r_old_hit;
    t_out_item         r_res;
    logic              r_out_valid;
    t_out_item         r_out_data;
    logic [WIN_W-1:0]  r_window;
    logic [CHANNELS-1:0] r_ch_valid;

    logic [WIN_W-1:0]  w_eff;
    logic              in_range;
    logic [CI_W-1:0]   in_ch;
    logic [ST_W-1:0]   st_rdata;
    logic [SAMPLE_W-1:0] hist_rdata;
    logic              fresh;
    logic [SUM_W-1:0]  n_sum_rd;
    logic [WIN_W-1:0]  n_cnt_rd;
    logic [SLOT_W-1:0] n_slot_rd;
    logic              n_old_hit;
    logic [PW-1:0]     slot_e;
    logic [PW-1:0]     win_e;
    logic [PW-1:0]     old_pos;
    logic [HA_W-1:0]   hist_raddr;
    logic [SUM_W-1:0]  n_old;
    logic [SUM_W-1:0]  n_sum;
    logic [WIN_W:0]    n_cnt_inc;
    logic [WIN_W-1:0]  n_cnt;
    logic [SLOT_W-1:0] n_slot;
    logic              n_warm;
    logic              div_done;
    logic signed [SAMPLE_W-1:0] div_q;

    always_comb begin
        if (r_window < WIN_W'(WIN_LOW)) begin
            w_eff = WIN_W'(WIN_LOW);
        end else if (r_window > WIN_W'(EFF_HIGH)) begin
            w_eff = WIN_W'(EFF_HIGH);
        end else begin
            w_eff = r_window;
        end
    end

    assign in_range = {3'b000, i_in_data.channel} < CH_LIM;
    assign in_ch    = CI_W'(i_in_data.channel);

    // channel state as read back, cleared for a new or never-used series
    always_comb begin
        fresh     = r_item.new_series || !r_ch_valid[r_ch];
        n_sum_rd  = fresh ? '0 : st_rdata[ST_W-1 -: SUM_W];
        n_cnt_rd  = fresh ? '0 : st_rdata[SLOT_W +: WIN_W];
        n_slot_rd = fresh ? '0 : st_rdata[SLOT_W-1:0];
        n_old_hit = n_cnt_rd >= w_eff;
        slot_e    = PW'(n_slot_rd);
        win_e     = PW'(w_eff);
        if (slot_e >= win_e) begin
            old_pos = slot_e - win_e;
        end else begin
            old_pos = slot_e + PW'(MAX_WINDOW) - win_e;
        end
        hist_raddr = r_base + HA_W'(old_pos[SLOT_W-1:0]);
    end

    // update with the sample leaving the window
    always_comb begin
        n_old     = r_old_hit ?
                    {{(SUM_W-SAMPLE_W){hist_rdata[SAMPLE_W-1]}}, hist_rdata} : '0;
        n_sum     = r_sum - n_old
                    + {{(SUM_W-SAMPLE_W){r_item.sample[SAMPLE_W-1]}}, r_item.sample};
        n_cnt_inc = {1'b0, r_cnt} + 1'b1;
        n_cnt     = (n_cnt_inc > {1'b0, w_eff}) ? w_eff : n_cnt_inc[WIN_W-1:0];
        n_slot    = (r_slot == SLOT_W'(MAX_WINDOW - 1)) ? '0 : r_slot + 1'b1;
        n_warm    = n_cnt < w_eff;
    end

    mma_ram #(
        .WIDTH (ST_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RD2),
        .i_waddr (r_ch),
        .i_wdata ({n_sum, n_cnt, n_slot}),
        .i_raddr (in_ch),
        .o_rdata (st_rdata)
    );

    mma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HIST_D)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RD2),
        .i_waddr (r_base + HA_W'(r_slot)),
        .i_wdata (r_item.sample),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    mma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_RD2) && !n_warm),
        .i_dividend (n_sum),
        .i_divisor  (w_eff),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_window    <= WIN_W'(WIN_RESET);
            r_ch_valid  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in_data;
                        r_ch   <= in_ch;
                        r_base <= HA_W'(in_ch * MAX_WINDOW);
                        r_res.out_channel <= i_in_data.channel;
                        r_res.average     <= i_in_data.sample;
                        r_res.warming_up  <= 1'b1;
                        r_state <= in_range ? S_RD1 : S_OUT;
                    end
                end
                S_RD1: begin
                    r_sum     <= n_sum_rd;
                    r_cnt     <= n_cnt_rd;
                    r_slot    <= n_slot_rd;
                    r_old_hit <= n_old_hit;
                    r_state   <= S_RD2;
                end
                S_RD2: begin
                    r_ch_valid[r_ch] <= 1'b1;
                    r_state <= n_warm ? S_OUT : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res.average    <= div_q;
                        r_res.warming_up <= 1'b0;
                        r_state          <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_data  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

/* hdl/mma_ram.sv */
module mma_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mma_div.sv */
module mma_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [mma_pkg::SUM_W-1:0]        i_dividend,
    input  logic [mma_pkg::WIN_W-1:0]        i_divisor,
    output logic                             o_done,
    output logic signed [mma_pkg::SAMPLE_W-1:0] o_quotient
);

    import mma_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic                       r_busy;
    logic                       r_fin;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [WIN_W-1:0]           r_rem;
    logic [SUM_W-1:0]           r_quo;
    logic [WIN_W-1:0]           r_div;
    logic                       r_neg;
    logic signed [SAMPLE_W-1:0] r_q;

    logic [WIN_W:0]             n_trial;
    logic                       n_ge;
    logic [WIN_W:0]             n_diff;
    logic [WIN_W-1:0]           n_rem;
    logic signed [SUM_W-1:0]    n_signed;
    logic signed [SAMPLE_W-1:0] n_sat;

    // one quotient bit per cycle, restoring
    always_comb begin
        n_trial  = {r_rem, r_quo[SUM_W-1]};
        n_ge     = n_trial >= {1'b0, r_div};
        n_diff   = n_trial - {1'b0, r_div};
        n_rem    = n_ge ? n_diff[WIN_W-1:0] : n_trial[WIN_W-1:0];
        n_signed = r_neg ? -$signed(r_quo) : $signed(r_quo);
        if (n_signed > SAT_MAX) begin
            n_sat = SAMPLE_W'(SAT_MAX);
        end else if (n_signed < SAT_MIN) begin
            n_sat = SAMPLE_W'(SAT_MIN);
        end else begin
            n_sat = n_signed[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_neg  <= i_dividend[SUM_W-1];
                r_quo  <= i_dividend[SUM_W-1] ? -i_dividend : i_dividend;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[SUM_W-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_q    <= n_sat;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

/* hdl/mma_chk.sv */
module mma_chk #(
    parameter int CHANNELS = mma_pkg::CHANNELS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mma_pkg::t_out_item o_out_data
);

    import mma_pkg::*;

    localparam logic [CH_W+2:0] CH_LIM = (CH_W + 3)'(CHANNELS);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // one item in flight: a transfer closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    // averaged results only exist for real channels
    a_avg_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.warming_up |->
            {3'b000, o_out_data.out_channel} < CH_LIM)
        else $error("average for an unknown channel");

endmodule

bind multichannel_moving_average mma_chk #(.CHANNELS(CHANNELS)) u_mma_chk (.*);
